@@ hdl/npcs_pkg.sv @@
// Shared types, codes and helpers for the nearest palette color search block.
// No dependencies; every other file of the block but npcs_ram imports this package.
package npcs_pkg;

  // Command codes carried by an input word
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Fixed field widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned DistW  = 10;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned WordW  = 4 * ChanW;

  // Input word
  typedef struct packed {
    logic              cmd;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  alpha;
  } npcs_in_t;

  // Result word
  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] nearest_index;
    logic [DistW-1:0]  best_distance;
  } npcs_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } npcs_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;    // clear best, capture query color
    logic              wr_en;    // store the input word in the palette
    logic              rd_en;    // read one palette entry
    logic [IndexW-1:0] rd_addr;
    logic              cmp_en;   // read data valid, compare it
    logic [IndexW-1:0] cmp_idx;
    logic              out_load; // move best into the output register
  } npcs_cmd_t;

  // Absolute difference of two channels
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ hdl/npcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/npcs_dp.sv @@
// Datapath: palette RAM, query color, L1 distance, running best and result register.
// Depends on npcs_pkg and npcs_ram.
module npcs_dp #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  npcs_pkg::npcs_cmd_t cmd_i,
  input  npcs_pkg::npcs_in_t  in_data_i,
  output npcs_pkg::npcs_out_t out_data_o
);
  import npcs_pkg::*;

  localparam int unsigned IdxW = $clog2(PALETTE_DEPTH);
  localparam logic [SizeW-1:0] DepthL = SizeW'(PALETTE_DEPTH);
  localparam logic [DistW-1:0] MaxDist = DistW'(4 * 255);

  logic [WordW-1:0] wr_word;
  logic             wr_ok;
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] query_q;
  logic [DistW-1:0] l1_dist;
  logic             best_found_q;
  logic [IndexW-1:0] best_idx_q;
  logic [DistW-1:0] best_dist_q;
  npcs_out_t        out_q;

  // Palette word: red in the low byte, alpha in the high byte
  assign wr_word = {in_data_i.alpha, in_data_i.blue, in_data_i.green, in_data_i.red};
  assign wr_ok   = cmd_i.wr_en && ({1'b0, in_data_i.entry_index} < DepthL);

  npcs_ram #(
    .Width(WordW),
    .Depth(PALETTE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(in_data_i.entry_index[IdxW-1:0]),
    .wdata_i(wr_word),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr[IdxW-1:0]),
    .rdata_o(rd_word)
  );

  // L1 distance of the entry just read to the query color
  always_comb begin
    l1_dist = DistW'(abs_diff(rd_word[7:0], query_q[7:0]))
            + DistW'(abs_diff(rd_word[15:8], query_q[15:8]))
            + DistW'(abs_diff(rd_word[23:16], query_q[23:16]))
            + DistW'(abs_diff(rd_word[31:24], query_q[31:24]));
  end

  // Query capture and running minimum; strict less keeps the lowest index on ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q      <= wr_word;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_dist_q  <= '0;
    end else if (cmd_i.cmp_en && (!best_found_q || l1_dist < best_dist_q)) begin
      best_found_q <= 1'b1;
      best_idx_q   <= cmd_i.cmp_idx;
      best_dist_q  <= l1_dist;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.found         <= best_found_q;
      out_q.nearest_index <= best_idx_q;
      out_q.best_distance <= best_dist_q;
    end
  end

  assign out_data_o = out_q;

  // Distance never exceeds four full channel swings
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp_en |-> l1_dist <= MaxDist)
    else $error("distance out of range");

  // The best index always lies inside the palette
  a_best_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmp_en && !cmd_i.start) |=> ({1'b0, best_idx_q} < DepthL))
    else $error("best index outside palette");

endmodule

@@ hdl/npcs_ctrl.sv @@
// Controller: handshakes, palette size register, scan counter and sequencing FSM.
// Depends on npcs_pkg.
module npcs_ctrl #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic                      cfg_we_i,
  input  logic [npcs_pkg::SizeW-1:0] cfg_wdata_i,
  output npcs_pkg::npcs_cmd_t       cmd_o
);
  import npcs_pkg::*;

  localparam int unsigned IdxW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [SizeW-1:0] DepthL = SizeW'(PALETTE_DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  npcs_state_e     state_q, state_d;
  logic [CntW-1:0] size_q, size_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            out_valid_q, out_valid_d;
  logic            in_acc;
  logic            query_acc;
  logic            out_free;

  assign in_acc    = in_valid_i && in_ready_o;
  assign query_acc = in_acc && (in_cmd_i == CMD_QUERY);
  assign out_free  = !out_valid_q || out_ready_i;

  // Palette size register, saturating at the palette depth
  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      size_d = (cfg_wdata_i > DepthL) ? CntW'(DepthL) : CntW'(cfg_wdata_i);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = (size_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_q == size_q - CntOne) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and counter
  always_comb begin
    in_ready_o     = 1'b0;
    addr_d         = addr_q;
    cmd_o          = '0;
    cmd_o.cmp_en   = rd_vld_q;
    cmd_o.cmp_idx  = IndexW'(rd_idx_q);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        addr_d      = '0;
        cmd_o.start = query_acc;
        cmd_o.wr_en = in_acc && (in_cmd_i == CMD_WRITE);
      end
      ST_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = IndexW'(addr_q[IdxW-1:0]);
        addr_d        = addr_q + CntOne;
      end
      ST_LAST: ;
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      addr_q      <= addr_d;
      rd_vld_q    <= cmd_o.rd_en;
      rd_idx_q    <= addr_q[IdxW-1:0];
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // Reads stay inside the configured palette size
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> addr_q < size_q)
    else $error("read beyond palette size");

  // A query on a non-empty palette starts a scan
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_acc && size_q != '0) |=> state_q == ST_SCAN)
    else $error("scan did not start");

  // Compare follows every read in the next cycle
  a_cmp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> cmd_o.cmp_en)
    else $error("read data not compared");

endmodule

@@ hdl/nearest_palette_color_search_top.sv @@
// Top level of the nearest palette color search (L1 distance) block.
// Depends on npcs_pkg, npcs_ctrl, npcs_dp (and npcs_ram through npcs_dp).
//
//   Channel  Signals                         Dir  Word
//   in       in_valid_i/in_ready_o/in_data_i  in  npcs_in_t: write entry or query
//   out      out_valid_o/out_ready_i/out_data_o out npcs_out_t: one per query
//   cfg      cfg_we_i/cfg_wdata_i            in  palette_size, no wait
//
// A write word is accepted in the idle state; writes can be accepted every cycle while no query
// is in progress. A query scans the palette after acceptance (an empty palette skips the scan):
// one palette RAM read port scanned one entry per cycle, a registered read, then one
// load. The next word is taken the cycle after the load.
// An output stall holds a finished query in the done state; writes are then
// not taken until the result register frees up. Reset clears control and
// palette_size only; palette entries are undefined until written.
module nearest_palette_color_search_top #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  npcs_pkg::npcs_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output npcs_pkg::npcs_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [npcs_pkg::SizeW-1:0] cfg_wdata_i
);
  import npcs_pkg::*;

  npcs_cmd_t cmd;

  // Sequencer
  npcs_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_o      (cmd)
  );

  // Palette storage and distance search
  npcs_dp #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

@@ sim/npcs_checker.sv @@
// Scoreboard for the nearest palette color search block: mirrors palette and size,
// predicts each query result and compares it with the result words seen on the bus.
// Depends on npcs_pkg.
`timescale 1ns / 1ps

module npcs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  npcs_pkg::npcs_in_t         in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  npcs_pkg::npcs_out_t        out_data_i,
  input  logic                       cfg_we_i,
  input  logic [npcs_pkg::SizeW-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  import npcs_pkg::*;

  localparam int unsigned Depth      = 256;
  localparam int          MaxPrinted = 40;

  // Mirror of the palette and of the effective scan length
  npcs_in_t    palette_mirror [Depth];
  int unsigned scan_len;
  npcs_out_t   nearest_q [$];
  int          fail_count = 0;
  int          checked    = 0;

  assign fail_count_o = fail_count;
  assign checked_o    = checked;

  // |x - y| widened to distance width
  function automatic logic [DistW-1:0] chan_gap(input logic [ChanW-1:0] x,
                                                input logic [ChanW-1:0] y);
    return (x > y) ? DistW'(x - y) : DistW'(y - x);
  endfunction

  // Scan the first scan_len entries; strict less-than keeps the lowest index on a tie
  function automatic npcs_out_t find_nearest(input npcs_in_t q);
    npcs_out_t        best;
    npcs_in_t         e;
    logic [DistW-1:0] d;
    best = '0;
    for (int unsigned i = 0; i < scan_len; i++) begin
      e = palette_mirror[i];
      d = chan_gap(e.red, q.red) + chan_gap(e.green, q.green)
        + chan_gap(e.blue, q.blue) + chan_gap(e.alpha, q.alpha);
      if (!best.found || d < best.best_distance) begin
        best.found         = 1'b1;
        best.nearest_index = IndexW'(i);
        best.best_distance = d;
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    if (fail_count < MaxPrinted) begin
      $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want_v);
    end
    fail_count++;
  endtask

  // Config, input word, then result word, all sampled at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    npcs_out_t want;
    if (!rst_ni) begin
      scan_len = 0;
      nearest_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        scan_len = (cfg_wdata_i > Depth) ? Depth : 32'(cfg_wdata_i);
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.cmd == CMD_WRITE) begin
          palette_mirror[in_data_i.entry_index] = in_data_i;
        end else begin
          nearest_q.push_back(find_nearest(in_data_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (nearest_q.size() == 0) begin
          report_mismatch("result word with no query outstanding, found",
                          32'(out_data_i.found), 32'd0);
        end else begin
          want = nearest_q.pop_front();
          if (out_data_i.found !== want.found) begin
            report_mismatch("found", 32'(out_data_i.found), 32'(want.found));
          end
          if (out_data_i.nearest_index !== want.nearest_index) begin
            report_mismatch("nearest_index", 32'(out_data_i.nearest_index),
                            32'(want.nearest_index));
          end
          if (out_data_i.best_distance !== want.best_distance) begin
            report_mismatch("best_distance", 32'(out_data_i.best_distance),
                            32'(want.best_distance));
          end
        end
      end
      pending_o <= nearest_q.size();
    end
  end

endmodule

@@ sim/tb_nearest_palette_color_search_top.sv @@
// Testbench top for nearest_palette_color_search_top: drives palette writes, queries
// and palette_size settings with random pacing; npcs_checker does the scoring.
// Depends on npcs_pkg, the block's RTL and npcs_checker.
`timescale 1ns / 1ps

module tb_nearest_palette_color_search_top;
  import npcs_pkg::*;

  localparam int RandomWords  = 1600;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 3_000_000;

  // Channels indexed 0 red, 1 green, 2 blue, 3 alpha
  typedef bit [3:0][ChanW-1:0] rgba_t;

  typedef enum int {
    RDY_OPEN,
    RDY_COIN,
    RDY_SPARSE,
    RDY_HOLD
  } ready_mode_e;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  npcs_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  npcs_out_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [SizeW-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int checked;

  // Stimulus-side view of what has been written, used only to shape colors
  rgba_t       shadow  [256];
  bit          written [256];
  int unsigned cur_size     = 0;
  int          burst_left   = 0;
  int          words_sent   = 0;
  int          queries_sent = 0;
  int          settings     = 0;
  int          cycle_count  = 0;

  ready_mode_e ready_mode = RDY_OPEN;
  int          ready_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_palette_color_search_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  npcs_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: segments of always-ready, coin-flip, sparse and fully stalled
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = (ready_mode == RDY_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    ready_left--;
    case (ready_mode)
      RDY_OPEN:   out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= 1'b0;
    endcase
  end

  // Extremes, exact copies or near neighbors of a live entry, or anything
  function automatic rgba_t pick_color();
    rgba_t c;
    rgba_t base;
    int    mode;
    int    j;
    mode = $urandom_range(0, 9);
    base = (cur_size != 0) ? shadow[$urandom_range(0, cur_size - 1)] : '0;
    for (int k = 0; k < 4; k++) begin
      case (mode)
        0, 1: c[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: c[k] = base[k];
        3, 4, 5: begin
          j = int'(base[k]) + int'($urandom_range(0, 6)) - 3;
          c[k] = (j < 0) ? 8'h00 : (j > 255) ? 8'hFF : ChanW'(j);
        end
        default: c[k] = ChanW'($urandom_range(0, 255));
      endcase
    end
    return c;
  endfunction

  // Send one word in the current burst; a new burst may open with a gap
  task automatic send_word(input logic cmd, input logic [IndexW-1:0] idx, input rgba_t c);
    npcs_in_t w;
    int       gap;
    w.cmd         = cmd;
    w.entry_index = idx;
    w.red         = c[0];
    w.green       = c[1];
    w.blue        = c[2];
    w.alpha       = c[3];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (cmd == CMD_QUERY) begin
      queries_sent++;
    end else begin
      shadow[idx]  = c;
      written[idx] = 1'b1;
    end
  endtask

  // Drop valid, wait for every result, then let trailing writes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_size(input logic [SizeW-1:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_size = (v > 256) ? 256 : 32'(v);
    settings++;
    // back-fill so a query never scans a slot that was never written
    for (int i = 0; i < cur_size; i++) begin
      if (!written[i]) begin
        send_word(CMD_WRITE, IndexW'(i), pick_color());
      end
    end
  endtask

  initial begin
    int               start_words;
    int               roll;
    int               phase_len;
    logic [SizeW-1:0] new_size;
    logic [IndexW-1:0] idx;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty palette right after reset: nothing scanned
    send_word(CMD_QUERY, 8'h00, '0);
    send_word(CMD_QUERY, 8'hFF, '1);

    // Black, white, a second black for the tie, and two odd patterns
    send_word(CMD_WRITE, 8'd0, '0);
    send_word(CMD_WRITE, 8'd1, '1);
    send_word(CMD_WRITE, 8'd2, '0);
    send_word(CMD_WRITE, 8'd255, {8'hA5, 8'h5A, 8'hC3, 8'h3C});
    send_word(CMD_WRITE, 8'd3, {8'h80, 8'h7F, 8'h01, 8'hFE});

    // Single entry: largest possible distance and zero distance
    set_size(9'd1);
    send_word(CMD_QUERY, 8'h5A, '1);
    send_word(CMD_QUERY, 8'hA5, '0);

    // Tie between equal entries, and the midpoint split
    set_size(9'd3);
    send_word(CMD_QUERY, 8'd0, '0);
    send_word(CMD_QUERY, 8'd0, '1);
    send_word(CMD_QUERY, 8'd0, {4{8'h7F}});
    send_word(CMD_QUERY, 8'd0, {4{8'h80}});

    // Full palette, then sizes beyond the depth that must saturate
    set_size(9'd256);
    send_word(CMD_QUERY, 8'd0, shadow[255]);
    send_word(CMD_QUERY, 8'd0, {8'h80, 8'h7F, 8'h01, 8'hFE});
    set_size(9'd511);
    send_word(CMD_QUERY, 8'd0, '1);
    set_size(9'd257);
    send_word(CMD_QUERY, 8'd0, '0);

    // Random phases, mostly small palettes so queries stay short
    start_words = words_sent;
    while (words_sent - start_words < RandomWords) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)       new_size = '0;
      else if (roll < 60) new_size = SizeW'($urandom_range(1, 8));
      else if (roll < 85) new_size = SizeW'($urandom_range(9, 40));
      else if (roll < 92) new_size = SizeW'($urandom_range(41, 255));
      else if (roll < 96) new_size = SizeW'(256);
      else                new_size = SizeW'($urandom_range(257, 511));
      set_size(new_size);
      phase_len = (cur_size > 64) ? $urandom_range(10, 30) : $urandom_range(40, 120);
      repeat (phase_len) begin
        if ($urandom_range(0, 1)) begin
          send_word(CMD_QUERY, IndexW'($urandom_range(0, 255)), pick_color());
        end else begin
          idx = (cur_size != 0 && $urandom_range(0, 9) < 7)
              ? IndexW'($urandom_range(0, cur_size - 1))
              : IndexW'($urandom_range(0, 255));
          send_word(CMD_WRITE, idx, pick_color());
        end
      end
    end

    wait_idle();
    $display("Covered %0d words (%0d queries) over %0d palette size settings; %0d results compared.",
             words_sent, queries_sent, settings, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
